>>> sv/bdlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_pkg: shared types and constants
// field widths, register indexes, reset values and the control and status
// structs that pass between the top level and the per-button cells
// ----------------------------------------------------------------------------
package bdlp_pkg;

    localparam int TIMER_WIDTH     = 16;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int PIN_WIDTH       = 3;
    localparam int INDEX_WIDTH     = 2;
    localparam int HIST_DEPTH      = 3;

    localparam logic [TIMER_WIDTH-1:0] LONG_PRESS_DELAY_RESET = 16'd2000;
    localparam logic [TIMER_WIDTH-1:0] REPEAT_PERIOD_RESET    = 16'd250;
    localparam logic                   PRESSED_LEVEL_RESET    = 1'b0;
    // released level for the reset of the sample history and the accepted level
    localparam logic                   RAW_LEVEL_RESET        = 1'b1;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_LONG_PRESS_DELAY = 2'd0,
        REG_REPEAT_PERIOD    = 2'd1,
        REG_PRESSED_LEVEL    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [TIMER_WIDTH-1:0] long_press_delay;
        logic [TIMER_WIDTH-1:0] repeat_period;
        logic                   pressed_level;
    } button_cfg_t;

    typedef struct packed {
        logic tick;
        logic read_clear;
    } button_ctrl_t;

    typedef struct packed {
        logic press_flag;        // current flag, before this beat
        logic long_press_next;   // long-press after this beat
        logic pressed_next;      // debounced pressed after this beat
    } button_status_t;

endpackage

>>> sv/bdlp_button.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_button: debounce and long-press cell for one button
// three-sample history, accepted level, hold timer, long-press and press flags
// ----------------------------------------------------------------------------
module bdlp_button (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bdlp_pkg::button_cfg_t   cfg,
    input  bdlp_pkg::button_ctrl_t  ctrl,
    input  logic                    level,
    output bdlp_pkg::button_status_t status
);
    import bdlp_pkg::*;

    logic [HIST_DEPTH-1:0]  hist_reg, hist_next;     // bit 0 is the oldest
    logic                   accepted_reg, accepted_next;
    logic [TIMER_WIDTH-1:0] timer_reg, timer_next;
    logic                   long_press_reg, long_press_next;
    logic                   press_flag_reg, press_flag_next;
    logic [TIMER_WIDTH-1:0] timer_dec;
    logic                   agree;

    assign timer_dec = timer_reg - TIMER_WIDTH'(1);
    assign agree     = (hist_reg[1] == level) && (hist_reg[2] == level);

    always_comb
    begin
        hist_next       = hist_reg;
        accepted_next   = accepted_reg;
        timer_next      = timer_reg;
        long_press_next = long_press_reg;
        press_flag_next = press_flag_reg;
        if (ctrl.tick)
        begin
            hist_next = {level, hist_reg[2:1]};
            if (agree)
            begin
                if (accepted_reg != level)
                begin
                    accepted_next = level;
                    if (level == cfg.pressed_level)
                    begin
                        press_flag_next = 1'b1;
                        timer_next = long_press_reg ? cfg.repeat_period
                                                    : cfg.long_press_delay;
                    end
                end
                else if (level == cfg.pressed_level)
                begin
                    timer_next = timer_dec;
                    if (timer_dec == '0)
                    begin
                        // force a release so the held button repeats
                        accepted_next   = ~cfg.pressed_level;
                        long_press_next = 1'b1;
                    end
                end
            end
            else
            begin
                long_press_next = 1'b0;
            end
        end
        else if (ctrl.read_clear)
        begin
            press_flag_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg       <= {HIST_DEPTH{RAW_LEVEL_RESET}};
            accepted_reg   <= RAW_LEVEL_RESET;
            timer_reg      <= '0;
            long_press_reg <= 1'b0;
            press_flag_reg <= 1'b0;
        end
        else
        begin
            hist_reg       <= hist_next;
            accepted_reg   <= accepted_next;
            timer_reg      <= timer_next;
            long_press_reg <= long_press_next;
            press_flag_reg <= press_flag_next;
        end
    end

    assign status.press_flag      = press_flag_reg;
    assign status.long_press_next = long_press_next;
    assign status.pressed_next    = (accepted_next == cfg.pressed_level);

endmodule

>>> sv/button_debounce_long_press.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_long_press: multi-button debouncer with long-press repeat
// per-button cells plus one output register on a valid/ready stream
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready): one beat is either a sample tick
//   (mode 0, pin_levels carries one raw sample per button) or a read
//   (mode 1, button_index picks the press flag to return and clear)
//   output channel (out_valid/out_ready): exactly one result beat per input
//   beat, in order, carrying the state as it stands after that beat
//   latency: the result is valid the cycle after the input beat is taken
//   throughput: one beat per cycle while out_ready allows; the whole update is a single pass of
//   per-button logic between the state registers and the output register
//   stall: in_ready stays high while the output register is empty or is
//   being drained in the same cycle, so a held result blocks only the
//   next beat and is never lost or duplicated
//   reset: every button is released, timers and flags are cleared, and the
//   registers return to 2000 / 250 / pressed-low
//   config (cfg_write/cfg_index/cfg_data): single-cycle writes, meant to
//   be issued while no beat is in flight; unused indexes are ignored
// ----------------------------------------------------------------------------
module button_debounce_long_press #(
    parameter int BUTTON_COUNT = 3
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_write,
    input  logic [bdlp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [bdlp_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    // input beats
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 mode,
    input  logic [bdlp_pkg::PIN_WIDTH-1:0]       pin_levels,
    input  logic [bdlp_pkg::INDEX_WIDTH-1:0]     button_index,
    // result beats
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 press_reported,
    output logic [bdlp_pkg::PIN_WIDTH-1:0]       long_press_active,
    output logic [bdlp_pkg::PIN_WIDTH-1:0]       accepted_pressed
);
    import bdlp_pkg::*;

    // configuration registers
    button_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_delay <= LONG_PRESS_DELAY_RESET;
            cfg_reg.repeat_period    <= REPEAT_PERIOD_RESET;
            cfg_reg.pressed_level    <= PRESSED_LEVEL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LONG_PRESS_DELAY: cfg_reg.long_press_delay <= cfg_data;
                REG_REPEAT_PERIOD:    cfg_reg.repeat_period    <= cfg_data;
                REG_PRESSED_LEVEL:    cfg_reg.pressed_level    <= cfg_data[0];
                default:              ; // no register behind this index
            endcase
        end
    end

    // handshake: the output register frees up when its beat is taken
    logic accept;
    logic out_valid_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // per-button cells
    button_status_t status [BUTTON_COUNT];
    logic [PIN_WIDTH-1:0] lp_next, pressed_next;

    for (genvar i = 0; i < BUTTON_COUNT; i++)
    begin : g_button
        button_ctrl_t ctrl;
        logic         level;

        assign ctrl.tick       = accept && (mode == MODE_TICK);
        // reads of a missing button match no cell and change nothing
        assign ctrl.read_clear = accept && (mode == MODE_READ)
                                 && (32'(button_index) == i);

        // buttons past the pin field always sample low
        if (i < PIN_WIDTH)
        begin : g_pin
            assign level = pin_levels[i];
        end
        else
        begin : g_no_pin
            assign level = 1'b0;
        end

        bdlp_button u_button (
            .clk    (clk),
            .rst_n  (rst_n),
            .cfg    (cfg_reg),
            .ctrl   (ctrl),
            .level  (level),
            .status (status[i])
        );
    end

    // only the first PIN_WIDTH (3) buttons have status bits on the ports
    for (genvar b = 0; b < PIN_WIDTH; b++)
    begin : g_out_bit
        if (b < BUTTON_COUNT)
        begin : g_used
            assign lp_next[b]      = status[b].long_press_next;
            assign pressed_next[b] = status[b].pressed_next;
        end
        else
        begin : g_unused
            assign lp_next[b]      = 1'b0;
            assign pressed_next[b] = 1'b0;
        end
    end

    // press flag of the addressed button, old value
    logic reported_next;

    always_comb
    begin
        reported_next = 1'b0;
        if (mode == MODE_READ)
        begin
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                if (32'(button_index) == i)
                begin
                    reported_next = status[i].press_flag;
                end
            end
        end
    end

    // output register
    logic                 reported_reg;
    logic [PIN_WIDTH-1:0] lp_reg, pressed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            reported_reg <= reported_next;
            lp_reg       <= lp_next;
            pressed_reg  <= pressed_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign press_reported    = reported_reg;
    assign long_press_active = lp_reg;
    assign accepted_pressed  = pressed_reg;

endmodule
